// ===== rtl/trpp_pkg.sv =====
// Shared types, codes and mode text for the TFTP read-request parser.
package trpp_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [3:0] OctetLen    = 4'd5;
  localparam logic [3:0] NetasciiLen = 4'd8;
  localparam logic [3:0] ModePosMax  = 4'd15;
  localparam logic [1:0] ZeroMax     = 2'd3;
  localparam logic [1:0] NameZeros   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CORRUPT = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic {
    MODE_OCTET    = 1'b0,
    MODE_NETASCII = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_NAME    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    logic       has_name;
    logic [7:0] name_byte;
    logic       has_verdict;
    status_e    status;
    mode_e      mode;
  } entry_t;

  function automatic logic [7:0] octet_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h4F;
      4'd1:    c = 8'h43;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h45;
      4'd4:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] netascii_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h4E;
      4'd1:    c = 8'h45;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h41;
      4'd4:    c = 8'h53;
      4'd5:    c = 8'h43;
      4'd6:    c = 8'h49;
      4'd7:    c = 8'h49;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    logic [7:0] u;
    u = (b >= 8'h61 && b <= 8'h7A) ? (b - 8'd32) : b;
    return u;
  endfunction

endpackage

// ===== rtl/tftp_read_request_parser.sv =====
// Top level of the TFTP read-request parser: front end, queue and back end.
//
//   channel | direction | handshake                | payload
//   packet  | in        | in_valid_i / in_stall_o  | packet_byte_i, end_of_packet_i
//   result  | out       | out_valid_o / out_stall_i| result_kind_o, name_byte_o, status_o,
//           |           |                          |   transfer_mode_o, last_result_o
//
// One packet byte is taken per cycle while the queue has room.
// A byte that yields a filename word and the verdict gives two result words, the name word first.
// The output register is the throughput limit: one result word per cycle while out_stall_i is low.
// Reset clears packet state, queue pointers and the output valid at once.
// Output stalls back up through the four-entry queue into in_stall_o.
module tftp_read_request_parser #(
  parameter int unsigned MAX_PACKET = 516
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] packet_byte_i,
  input  logic       end_of_packet_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       result_kind_o,
  output logic [7:0] name_byte_o,
  output logic [1:0] status_o,
  output logic       transfer_mode_o,
  output logic       last_result_o
);

  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  trpp_pkg::entry_t push_entry;
  trpp_pkg::entry_t head;

  trpp_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .packet_byte_i  (packet_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  trpp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  trpp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .name_byte_o    (name_byte_o),
    .status_o       (status_o),
    .transfer_mode_o(transfer_mode_o),
    .last_result_o  (last_result_o)
  );

endmodule

// ===== rtl/trpp_front.sv =====
// Front end: accepts packet bytes, tracks packet state and classifies each byte.
module trpp_front #(
  parameter int unsigned MAX_PACKET = 516
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       packet_byte_i,
  input  logic             end_of_packet_i,
  input  logic             q_full_i,
  output logic             push_o,
  output trpp_pkg::entry_t push_entry_o
);

  localparam logic [9:0] MaxIdx = 10'(MAX_PACKET);

  logic [9:0] byte_idx_q, byte_idx_d;
  logic [1:0] zero_cnt_q, zero_cnt_d;
  logic       too_many_q, too_many_d;
  logic       first_bad_q, first_bad_d;
  logic [3:0] mode_pos_q, mode_pos_d;
  logic       oct_ok_q, oct_ok_d;
  logic       net_ok_q, net_ok_d;
  logic       len_ovf_q, len_ovf_d;

  logic       accept;
  logic       is_zero;
  logic       in_mode;
  logic       is_name;
  logic [7:0] up;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_zero    = (packet_byte_i == 8'd0);
  assign in_mode    = (zero_cnt_q == trpp_pkg::NameZeros) && !too_many_q;
  assign is_name    = (byte_idx_q >= 10'd2) && (zero_cnt_q < trpp_pkg::NameZeros);
  assign up         = trpp_pkg::fold_upper(packet_byte_i);

  always_comb begin
    first_bad_d = first_bad_q || ((byte_idx_q == 10'd0) && !is_zero);
    len_ovf_d   = len_ovf_q || (byte_idx_q >= MaxIdx);
    oct_ok_d    = oct_ok_q;
    net_ok_d    = net_ok_q;
    mode_pos_d  = mode_pos_q;
    if (in_mode) begin
      if (mode_pos_q < trpp_pkg::OctetLen && up != trpp_pkg::octet_char(mode_pos_q)) begin
        oct_ok_d = 1'b0;
      end
      if (mode_pos_q < trpp_pkg::NetasciiLen
          && up != trpp_pkg::netascii_char(mode_pos_q)) begin
        net_ok_d = 1'b0;
      end
      if (mode_pos_q != trpp_pkg::ModePosMax) begin
        mode_pos_d = mode_pos_q + 4'd1;
      end
    end
    zero_cnt_d = zero_cnt_q;
    too_many_d = too_many_q;
    if (is_zero) begin
      if (zero_cnt_q == trpp_pkg::ZeroMax) begin
        too_many_d = 1'b1;
      end else begin
        zero_cnt_d = zero_cnt_q + 2'd1;
      end
    end
    byte_idx_d = (byte_idx_q != 10'd1023) ? (byte_idx_q + 10'd1) : byte_idx_q;
  end

  always_comb begin
    push_entry_o             = '0;
    push_entry_o.has_name    = is_name;
    push_entry_o.name_byte   = is_name ? packet_byte_i : 8'd0;
    push_entry_o.has_verdict = end_of_packet_i;
    push_entry_o.status      = trpp_pkg::ST_UNKNOWN;
    push_entry_o.mode        = trpp_pkg::MODE_OCTET;
    if (too_many_d || zero_cnt_d < trpp_pkg::NameZeros || first_bad_d || len_ovf_d) begin
      push_entry_o.status = trpp_pkg::ST_CORRUPT;
    end else if (oct_ok_d && mode_pos_d >= trpp_pkg::OctetLen) begin
      push_entry_o.status = trpp_pkg::ST_OK;
    end else if (net_ok_d && mode_pos_d >= trpp_pkg::NetasciiLen) begin
      push_entry_o.status = trpp_pkg::ST_OK;
      push_entry_o.mode   = trpp_pkg::MODE_NETASCII;
    end
  end

  assign push_o = accept && (is_name || end_of_packet_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q  <= '0;
      zero_cnt_q  <= '0;
      too_many_q  <= 1'b0;
      first_bad_q <= 1'b0;
      mode_pos_q  <= '0;
      oct_ok_q    <= 1'b1;
      net_ok_q    <= 1'b1;
      len_ovf_q   <= 1'b0;
    end else if (accept) begin
      if (end_of_packet_i) begin
        byte_idx_q  <= '0;
        zero_cnt_q  <= '0;
        too_many_q  <= 1'b0;
        first_bad_q <= 1'b0;
        mode_pos_q  <= '0;
        oct_ok_q    <= 1'b1;
        net_ok_q    <= 1'b1;
        len_ovf_q   <= 1'b0;
      end else begin
        byte_idx_q  <= byte_idx_d;
        zero_cnt_q  <= zero_cnt_d;
        too_many_q  <= too_many_d;
        first_bad_q <= first_bad_d;
        mode_pos_q  <= mode_pos_d;
        oct_ok_q    <= oct_ok_d;
        net_ok_q    <= net_ok_d;
        len_ovf_q   <= len_ovf_d;
      end
    end
  end

  a_fourth_zero_only_at_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    too_many_q |-> zero_cnt_q == trpp_pkg::ZeroMax)
    else $error("too_many set below three zeros");

endmodule

// ===== rtl/trpp_queue.sv =====
// Short queue of classified words between the front end and the back end.
module trpp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  trpp_pkg::entry_t push_entry_i,
  input  logic             pop_i,
  output trpp_pkg::entry_t head_o,
  output logic             empty_o,
  output logic             full_o
);

  trpp_pkg::entry_t             mem_q [trpp_pkg::QDepth];
  logic [trpp_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [trpp_pkg::QCntW-1:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == trpp_pkg::QCntW'(trpp_pkg::QDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + trpp_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + trpp_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + trpp_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - trpp_pkg::QCntW'(1);
      end
    end
  end

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= trpp_pkg::QCntW'(trpp_pkg::QDepth))
    else $error("queue count out of range");

endmodule

// ===== rtl/trpp_back.sv =====
// Back end: splits each queued word into result words and drives the output register.
module trpp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  trpp_pkg::entry_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             result_kind_o,
  output logic [7:0]       name_byte_o,
  output logic [1:0]       status_o,
  output logic             transfer_mode_o,
  output logic             last_result_o
);

  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] name_q;
  logic [1:0] status_q;
  logic       mode_q;
  logic       last_q;
  logic       name_done_q;
  logic       load;
  logic       send_name;

  assign load      = (!out_valid_q || !out_stall_i) && !empty_i;
  assign send_name = head_i.has_name && !name_done_q;
  assign pop_o     = load && !(send_name && head_i.has_verdict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      name_done_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= !empty_i;
      if (load) begin
        name_done_q <= send_name && head_i.has_verdict;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (send_name) begin
        kind_q   <= trpp_pkg::KIND_NAME;
        name_q   <= head_i.name_byte;
        status_q <= trpp_pkg::ST_OK;
        mode_q   <= trpp_pkg::MODE_OCTET;
        last_q   <= 1'b0;
      end else begin
        kind_q   <= trpp_pkg::KIND_VERDICT;
        name_q   <= 8'd0;
        status_q <= head_i.status;
        mode_q   <= head_i.mode;
        last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign name_byte_o     = name_q;
  assign status_o        = status_q;
  assign transfer_mode_o = mode_q;
  assign last_result_o   = last_q;

  a_split_keeps_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    name_done_q |-> !empty_i && head_i.has_name && head_i.has_verdict)
    else $error("split word lost its queue head");

  a_verdict_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == trpp_pkg::KIND_VERDICT |-> last_q && name_q == 8'd0)
    else $error("verdict word malformed");

endmodule
